>>> hdl/mhft_pkg.sv
// Shared types, constants and helpers for the mail header field tokenizer.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package mhft_pkg;

  localparam int unsigned MaxRes = 5;   // most results one input byte can cause
  localparam int unsigned CntW   = $clog2(MaxRes + 1);
  localparam int unsigned IdxW   = $clog2(MaxRes);

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChF     = 8'h46;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef enum logic [2:0] {
    ROLE_KEY_BYTE   = 3'd0,
    ROLE_KEY_DONE   = 3'd1,
    ROLE_VALUE_BYTE = 3'd2,
    ROLE_FIELD_DONE = 3'd3,
    ROLE_FROM_BYTE  = 3'd4,
    ROLE_FROM_DONE  = 3'd5,
    ROLE_HDRS_DONE  = 3'd6
  } role_e;

  typedef struct packed {
    logic [7:0] data;
    role_e      role;
  } res_t;

  // All results caused by one input byte, in output order.
  typedef struct packed {
    logic [CntW-1:0]     cnt;
    res_t [MaxRes-1:0]   ent;
  } rset_t;

  // Bytes of the separator prefix "From ".
  function automatic logic [7:0] sep_char(input logic [IdxW-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = ChF;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h6F;
      3'd3:    c = 8'h6D;
      3'd4:    c = ChSpace;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/mhft_parser.sv
// Input word register, parse state and the single-pass tokenizing logic.
// Depends on mhft_pkg; feeds a complete result set to mhft_outbuf.
`timescale 1ns / 1ps

module mhft_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_start_i,
  input  logic                out_free_i,
  output logic                out_load_o,
  output mhft_pkg::rset_t     out_rset_o
);
  import mhft_pkg::*;

  typedef enum logic [8:0] {
    PH_LEAD     = 9'b000000001,
    PH_LINE     = 9'b000000010,
    PH_PREFIX   = 9'b000000100,
    PH_FROM     = 9'b000001000,
    PH_KEY      = 9'b000010000,
    PH_COLON    = 9'b000100000,
    PH_VALUE    = 9'b001000000,
    PH_AFTER_LF = 9'b010000000,
    PH_DONE     = 9'b100000000
  } phase_e;

  logic          in_vld_q, in_vld_d;
  logic [7:0]    in_byte_q;
  logic          in_start_q;
  phase_e        phase_q, phase_d;
  logic [2:0]    pm_q, pm_d;

  logic          adv;
  phase_e        ph;
  logic [2:0]    pm;
  logic [7:0]    b;
  logic          is_crlf;
  logic [2:0]    pfx_n;
  role_e         pfx_role;
  logic          t0v, t1v, do_ls, do_key;
  res_t          t0, t1, kent;
  rset_t         rset;

  assign adv        = in_vld_q && out_free_i;
  assign in_ready_o = !in_vld_q || adv;
  assign in_vld_d   = in_ready_o ? in_valid_i : in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q  <= in_byte_i;
      in_start_q <= in_start_i;
    end
  end

  always_comb begin
    ph       = in_start_q ? PH_LEAD : phase_q;
    pm       = in_start_q ? 3'd0 : pm_q;
    b        = in_byte_q;
    is_crlf  = (b == ChCr) || (b == ChLf);
    phase_d  = ph;
    pm_d     = pm;
    pfx_n    = 3'd0;
    pfx_role = ROLE_KEY_BYTE;
    t0v      = 1'b0;
    t1v      = 1'b0;
    t0       = '{data: 8'h00, role: ROLE_KEY_BYTE};
    t1       = '{data: 8'h00, role: ROLE_KEY_BYTE};
    kent     = '{data: 8'h00, role: ROLE_KEY_BYTE};
    do_ls    = 1'b0;
    do_key   = 1'b0;

    unique case (ph)
      PH_LEAD: begin
        if (!is_crlf) do_ls = 1'b1;
      end
      PH_LINE: begin
        do_ls = 1'b1;
      end
      PH_PREFIX: begin
        if (pm < 3'd5 && b == sep_char(pm)) begin
          if (pm == 3'd4) begin
            // full "From " seen: release it as from bytes
            pfx_n    = 3'd5;
            pfx_role = ROLE_FROM_BYTE;
            pm_d     = 3'd0;
            phase_d  = PH_FROM;
          end else begin
            pm_d = pm + 3'd1;
          end
        end else begin
          // mismatch: held bytes become key bytes, then this byte parses as key
          pfx_n  = (pm > 3'd5) ? 3'd5 : pm;
          pm_d   = 3'd0;
          do_key = 1'b1;
        end
      end
      PH_FROM: begin
        if (b == ChLf) begin
          t0v     = 1'b1;
          t0      = '{data: 8'h00, role: ROLE_FROM_DONE};
          phase_d = PH_KEY;
        end else if (b != ChCr) begin
          t0v = 1'b1;
          t0  = '{data: b, role: ROLE_FROM_BYTE};
        end
      end
      PH_KEY: begin
        do_key = 1'b1;
      end
      PH_COLON: begin
        phase_d = PH_VALUE;
      end
      PH_VALUE: begin
        if (b == ChLf) begin
          phase_d = PH_AFTER_LF;
        end else if (b != ChCr && b != ChTab) begin
          t0v = 1'b1;
          t0  = '{data: b, role: ROLE_VALUE_BYTE};
        end
      end
      PH_AFTER_LF: begin
        if (b == ChSpace || b == ChTab) begin
          // folded line: leading space is kept, leading tab dropped
          phase_d = PH_VALUE;
          if (b == ChSpace) begin
            t0v = 1'b1;
            t0  = '{data: b, role: ROLE_VALUE_BYTE};
          end
        end else begin
          t0v = 1'b1;
          t0  = '{data: 8'h00, role: ROLE_FIELD_DONE};
          if (is_crlf) begin
            t1v     = 1'b1;
            t1      = '{data: 8'h00, role: ROLE_HDRS_DONE};
            phase_d = PH_DONE;
          end else begin
            do_ls = 1'b1;
          end
        end
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase

    if (do_ls) begin
      if (b == ChF) begin
        pm_d    = 3'd1;
        phase_d = PH_PREFIX;
      end else begin
        do_key = 1'b1;
      end
    end

    if (do_key) begin
      if (b == ChColon) begin
        kent    = '{data: 8'h00, role: ROLE_KEY_DONE};
        phase_d = PH_COLON;
      end else begin
        kent    = '{data: b, role: ROLE_KEY_BYTE};
        phase_d = PH_KEY;
      end
      if (t0v) begin
        t1v = 1'b1;
        t1  = kent;
      end else begin
        t0v = 1'b1;
        t0  = kent;
      end
    end
  end

  // Lay out prefix bytes first, then up to two trailing results.
  always_comb begin
    rset.cnt = CntW'(pfx_n) + CntW'(t0v) + CntW'(t1v);
    for (int j = 0; j < MaxRes; j++) begin
      if (3'(j) < pfx_n) begin
        rset.ent[j] = '{data: sep_char(IdxW'(j)), role: pfx_role};
      end else if (3'(j) == pfx_n) begin
        rset.ent[j] = t0;
      end else begin
        rset.ent[j] = t1;
      end
    end
  end

  assign out_load_o = adv;
  assign out_rset_o = rset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      pm_q    <= 3'd0;
    end else if (adv) begin
      phase_q <= phase_d;
      pm_q    <= pm_d;
    end
  end

  a_pm_only_in_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pm_q != 3'd0) |-> (phase_q == PH_PREFIX))
    else $error("prefix count held outside prefix phase");

  a_done_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !in_start_q && phase_q == PH_DONE) |-> (rset.cnt == '0))
    else $error("result produced after end of header block");

  a_load_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |-> (in_vld_q && out_free_i))
    else $error("result set loaded without a held input word");

endmodule

>>> hdl/mhft_outbuf.sv
// Result register: holds one result set and hands out one word per cycle on ready.
// Depends on mhft_pkg; loaded by mhft_parser.
`timescale 1ns / 1ps

module mhft_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mhft_pkg::rset_t   rset_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic [2:0]        out_role_o,
  output logic              out_last_o
);
  import mhft_pkg::*;

  res_t [MaxRes-1:0] ent_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [IdxW-1:0]   rd_q, rd_d;
  logic              take, at_last;

  assign out_valid_o = (cnt_q != '0);
  assign at_last     = (CntW'(rd_q) == cnt_q - CntW'(1));
  assign take        = out_valid_o && out_ready_i;
  assign free_o      = !out_valid_o || (take && at_last);

  assign out_byte_o = ent_q[rd_q].data;
  assign out_role_o = ent_q[rd_q].role;
  assign out_last_o = at_last;

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (load_i && rset_i.cnt != '0) begin
      cnt_d = rset_i.cnt;
      rd_d  = '0;
    end else if (take) begin
      if (at_last) begin
        cnt_d = '0;
        rd_d  = '0;
      end else begin
        rd_d = rd_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && rset_i.cnt != '0) begin
      ent_q <= rset_i.ent;
    end
  end

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CntW'(rd_q) < cnt_q))
    else $error("read index beyond held result count");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && rset_i.cnt != '0) |-> free_o)
    else $error("result set loaded over undelivered results");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && at_last && !load_i) |=> !out_valid_o)
    else $error("buffer still valid after its final word was taken");

endmodule

>>> hdl/mail_header_field_tokenizer.sv
// Top level of the mail header field tokenizer.
// Depends on mhft_pkg, mhft_parser and mhft_outbuf.
`timescale 1ns / 1ps

// Usage
//   Slave channel (s_axis_*): one raw header byte per word. tuser[0] set on
//   the first byte of a new header block restarts the tokenizer before that
//   byte is parsed.
//   Master channel (m_axis_*): one token word per result. tuser carries the
//   role (key byte, key done, value byte, field done, from byte, from done,
//   headers done); tdata carries the byte, zero for marker roles. tlast marks
//   the final token caused by one input byte. Bytes that are dropped (line
//   breaks, CR/TAB inside values, held "From " prefix bytes, bytes after the
//   end of the block) cause no token at all.
//   Path: a byte's tokens pass the input word register, then the result
//   register, which presents them; a busy result register holds the byte
//   in the input word register until it frees.
//   Throughput: one input byte per cycle while each byte yields at most one
//   token and m_axis_tready is high; a byte with more tokens holds the result
//   register until its last token is taken, as tokens leave one per cycle.
//   Reset: clears both valid flags and puts the parser in its leading line
//   break skip state with an empty prefix count.
//   Stall: while m_axis_tready is low the result register holds its word;
//   the input register still takes one more byte, then s_axis_tready drops.
module mail_header_field_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] block_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]  m_axis_tuser,   // [2:0] role
  output logic        m_axis_tlast    // last token of this input byte
);
  import mhft_pkg::*;

  logic  out_free;
  logic  out_load;
  rset_t rset;

  // Parse one byte per cycle, while the output buffer is free, into a complete set of tokens.
  mhft_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_start_i (s_axis_tuser[0]),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .out_rset_o (rset)
  );

  // Hold the token set and drain it one word per cycle while m_axis_tready is high.
  mhft_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .rset_i      (rset),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_role_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> test/tb.sv
// Testbench for mail_header_field_tokenizer: streams raw header bytes in and
// checks every token word against a byte-level tokenizer model kept here.
// Depends on mhft_pkg (role codes, character constants) and the block's RTL.
`timescale 1ns / 1ps

module tb;
  import mhft_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam logic [39:0] SEP_TEXT      = "From ";

  // Parse position of the tokenizer model.
  typedef enum logic [3:0] {
    P_SKIP,      // skipping leading CR/LF
    P_PREFIX,    // holding bytes that may still spell the separator prefix
    P_SEP_LINE,  // inside a separator line
    P_KEY,
    P_COLON,     // byte right after the colon
    P_VALUE,
    P_AFTER_LF,  // first byte of the next line decides fold or new field
    P_DONE       // blank line seen, ignore until restart
  } parse_e;

  typedef struct packed {
    logic [7:0] data;
    role_e      role;
    logic       last;
  } token_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic [0:0] s_axis_tuser  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       m_axis_tlast;

  // Tokenizer model state and expected tokens.
  parse_e      tok_phase = P_SKIP;
  int          from_cnt  = 0;
  token_t      pending[$];
  token_t      tokens_due[$];

  // Run bookkeeping.
  int unsigned err_cnt        = 0;
  int unsigned bytes_sent     = 0;
  int unsigned tokens_checked = 0;
  int unsigned blocks_sent    = 0;
  int unsigned cycle_cnt      = 0;

  // Idling controls for the sender and the receiver.
  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  int unsigned hold_asked   = 0;
  int unsigned hold_served  = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_stall_left = 0;

  mail_header_field_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Tokenizer model
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] sep_byte(input int idx);
    return SEP_TEXT[39 - 8*idx -: 8];
  endfunction

  function automatic void emit_token(input logic [7:0] d, input role_e r);
    token_t t;
    t.data = d;
    t.role = r;
    t.last = 1'b0;
    pending.push_back(t);
  endfunction

  // A colon closes the key; every other byte, line breaks included, joins it.
  function automatic void key_char(input logic [7:0] b);
    if (b == ChColon) begin
      emit_token(8'h00, ROLE_KEY_DONE);
      tok_phase = P_COLON;
    end else begin
      emit_token(b, ROLE_KEY_BYTE);
    end
  endfunction

  // LF ends the value line; drop CR and TAB.
  function automatic void value_char(input logic [7:0] b);
    if (b == ChLf) begin
      tok_phase = P_AFTER_LF;
    end else if (b != ChCr && b != ChTab) begin
      emit_token(b, ROLE_VALUE_BYTE);
    end
  endfunction

  // An 'F' may open a separator line; hold it until the prefix decides.
  function automatic void line_start(input logic [7:0] b);
    if (b == ChF) begin
      from_cnt  = 1;
      tok_phase = P_PREFIX;
    end else begin
      tok_phase = P_KEY;
      key_char(b);
    end
  endfunction

  // Advance the model by one accepted byte and queue the tokens it causes.
  function automatic void tokenize_byte(input logic [7:0] b, input logic restart);
    int i;
    pending.delete();
    if (restart) begin
      tok_phase = P_SKIP;
      from_cnt  = 0;
    end
    case (tok_phase)
      P_SKIP: begin
        if (b != ChCr && b != ChLf) line_start(b);
      end
      P_PREFIX: begin
        if (b == sep_byte(from_cnt)) begin
          from_cnt++;
          if (from_cnt == 5) begin
            for (i = 0; i < 5; i++) emit_token(sep_byte(i), ROLE_FROM_BYTE);
            from_cnt  = 0;
            tok_phase = P_SEP_LINE;
          end
        end else begin
          // Prefix broken: release the held bytes as key bytes, then parse b.
          for (i = 0; i < from_cnt; i++) emit_token(sep_byte(i), ROLE_KEY_BYTE);
          from_cnt  = 0;
          tok_phase = P_KEY;
          key_char(b);
        end
      end
      P_SEP_LINE: begin
        if (b == ChLf) begin
          emit_token(8'h00, ROLE_FROM_DONE);
          tok_phase = P_KEY;
        end else if (b != ChCr) begin
          emit_token(b, ROLE_FROM_BYTE);
        end
      end
      P_KEY:   key_char(b);
      P_COLON: tok_phase = P_VALUE;
      P_VALUE: value_char(b);
      P_AFTER_LF: begin
        if (b == ChSpace || b == ChTab) begin
          tok_phase = P_VALUE;
          value_char(b);
        end else begin
          emit_token(8'h00, ROLE_FIELD_DONE);
          if (b == ChCr || b == ChLf) begin
            emit_token(8'h00, ROLE_HDRS_DONE);
            tok_phase = P_DONE;
          end else begin
            line_start(b);
          end
        end
      end
      default: tok_phase = P_DONE;
    endcase
    if (pending.size() > 0) pending[pending.size() - 1].last = 1'b1;
    foreach (pending[i]) tokens_due.push_back(pending[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors
  // ---------------------------------------------------------------------------

  // Predict on every accepted input word.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      tokenize_byte(s_axis_tdata, s_axis_tuser[0]);
    end
  end

  task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
    err_cnt++;
    $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
  endtask

  // Compare every accepted token word with the oldest expected token.
  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tokens_due.size() == 0) begin
        err_cnt++;
        $display("%0t ns: unexpected token, expected none, got data %h role %0d last %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = tokens_due.pop_front();
        if (m_axis_tdata !== want.data) report("data", want.data, m_axis_tdata);
        if (m_axis_tuser !== want.role) report("role", 8'(want.role), 8'(m_axis_tuser));
        if (m_axis_tlast !== want.last) report("last", 8'(want.last), 8'(m_axis_tlast));
        tokens_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("%0t ns: timeout with %0d tokens still due", $time, tokens_due.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Idling
  // ---------------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: a requested long hold wins, then random stalls when enabled.
  always @(posedge clk_i) begin
    int unsigned stall;
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served++;
      rx_hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rx_stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_idle) begin
      stall = idle_len();
      if (stall != 0 && $urandom_range(0, 2) == 0) begin
        rx_stall_left = stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one byte, optionally after a gap, and hold it until accepted.
  task automatic send_byte(input logic [7:0] b, input logic restart);
    int unsigned gap;
    gap = tx_idle ? idle_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  function automatic logic [7:0] rand_key_char();
    int unsigned r;
    logic [7:0]  c;
    r = $urandom_range(0, 99);
    if (r < 80) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 90) return 8'h41 + 8'($urandom_range(0, 25));
    if (r < 95) return $urandom_range(0, 1) ? ChCr : ChLf;
    do c = 8'($urandom_range(0, 255)); while (c == ChColon);
    return c;
  endfunction

  function automatic logic [7:0] rand_value_char();
    int unsigned r;
    logic [7:0]  c;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(8'h21, 8'h7E));
    if (r < 80) begin
      case ($urandom_range(0, 2))
        0:       return ChSpace;
        1:       return ChTab;
        default: return ChCr;
      endcase
    end
    do c = 8'($urandom_range(0, 255)); while (c == ChLf);
    return c;
  endfunction

  // Build one well-formed header block with random content, now and then cut
  // short, and send it with block_start on its first byte. Returns the count
  // of bytes sent, less the ignored tail after the blank line.
  task automatic send_header_block(output int unsigned used);
    logic [7:0]  blk[$];
    int unsigned n_fields;
    int unsigned n_junk;
    int unsigned cut;
    int unsigned i;
    int unsigned k;
    repeat ($urandom_range(0, 2)) blk.push_back($urandom_range(0, 1) ? ChCr : ChLf);
    if ($urandom_range(0, 9) < 3) begin
      // Separator line with a random tail.
      for (i = 0; i < 5; i++) blk.push_back(sep_byte(i));
      repeat ($urandom_range(0, 6)) blk.push_back(rand_value_char());
      blk.push_back(ChCr);
      blk.push_back(ChLf);
    end else if ($urandom_range(0, 9) == 0) begin
      // Near miss on the separator prefix.
      k = $urandom_range(1, 4);
      for (i = 0; i < k; i++) blk.push_back(sep_byte(i));
    end
    n_fields = $urandom_range(1, 3);
    for (i = 0; i < n_fields; i++) begin
      repeat ($urandom_range(1, 5)) blk.push_back(rand_key_char());
      blk.push_back(ChColon);
      blk.push_back($urandom_range(0, 4) != 0 ? ChSpace : 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 6)) blk.push_back(rand_value_char());
      blk.push_back(ChCr);
      blk.push_back(ChLf);
      if ($urandom_range(0, 9) < 3) begin
        blk.push_back($urandom_range(0, 1) ? ChSpace : ChTab);
        repeat ($urandom_range(0, 5)) blk.push_back(rand_value_char());
        blk.push_back(ChLf);
      end
    end
    if ($urandom_range(0, 1)) blk.push_back(ChCr);
    blk.push_back(ChLf);
    used = blk.size();
    // Bytes past the blank line are ignored by the block.
    n_junk = $urandom_range(0, 2);
    repeat (n_junk) blk.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, blk.size());
      while (blk.size() > cut) void'(blk.pop_back());
      if (used > cut) used = cut;
    end
    foreach (blk[i]) send_byte(blk[i], i == 0);
    blocks_sent++;
  endtask

  // Leading line breaks, a prefix broken by the colon, the dropped byte after
  // the colon, CR/TAB dropped in a value, and a fold that starts with a space.
  task automatic test_prefix_miss_and_value();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_byte(ChLf, 1'b1);
    send_byte(ChCr, 1'b0);
    send_byte(ChF, 1'b0);
    send_byte("r", 1'b0);
    send_byte(ChColon, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(ChTab, 1'b0);
    send_byte(ChCr, 1'b0);
    send_byte(ChLf, 1'b0);
    send_byte(ChSpace, 1'b0);
    send_byte(ChLf, 1'b0);
  endtask

  // A full separator line, a key that starts with a line break right after
  // it, a fold that starts with a tab, the blank line, and ignored bytes.
  task automatic test_from_line_and_end();
    send_byte(ChF, 1'b0);
    send_byte("r", 1'b0);
    send_byte("o", 1'b0);
    send_byte("m", 1'b0);
    send_byte(ChSpace, 1'b0);
    send_byte(ChCr, 1'b0);
    send_byte(ChLf, 1'b0);
    send_byte(ChCr, 1'b0);
    send_byte(ChColon, 1'b0);
    send_byte("v", 1'b0);
    send_byte(ChLf, 1'b0);
    send_byte(ChTab, 1'b0);
    send_byte(ChLf, 1'b0);
    send_byte(ChCr, 1'b0);
    send_byte("A", 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // Mostly well-formed blocks with random content, some raw noise with random
  // restarts mixed in.
  task automatic test_random_traffic(input int unsigned n_items, input bit idle);
    int unsigned done_cnt;
    int unsigned used;
    int unsigned i;
    tx_idle  = idle;
    rx_idle  = idle;
    done_cnt = 0;
    while (done_cnt < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        send_header_block(used);
        done_cnt += used;
      end else begin
        used = $urandom_range(4, 12);
        for (i = 0; i < used; i++) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 15);
        end
        done_cnt += used;
      end
    end
  endtask

  // Long receiver hold while the sender streams two header blocks: the
  // output register and the input register fill and s_axis_tready drops.
  task automatic test_output_hold();
    int unsigned used;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_asked++;
    repeat (2) send_header_block(used);
  endtask

  // Wait for every due token, then let the pipeline settle.
  task automatic drain_and_settle();
    int unsigned waited;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (tokens_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tokens_due.size() != 0) begin
      err_cnt += tokens_due.size();
      $display("%0t ns: %0d expected tokens never arrived", $time, tokens_due.size());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_prefix_miss_and_value();
    test_from_line_and_end();
    test_random_traffic(80, 1'b1);
    test_output_hold();
    test_random_traffic(30, 1'b0);
    drain_and_settle();

    $display("tb: %0d bytes in, %0d tokens checked, %0d header blocks",
             bytes_sent, tokens_checked, blocks_sent);
    $display("tb: prefix hits and misses, folds, blank-line end, noise, long output hold");
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
